// File: hw/rtl/b2h_pkg.sv
// Shared types, codes and constants of the BGR to HSV pixel converter.
`default_nettype none

package b2h_pkg;

    // Channel and datapath widths.
    localparam int CH_W      = 8;
    localparam int NUM_W     = 16;
    localparam int HNUM_W    = 18;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Pipeline depth: front stage, numerator stage, one stage per quotient bit.
    localparam int NUM_STAGES = DIV_STEPS + 2;

    // Hue arithmetic in half degrees.
    localparam int HUE_SCALE     = 30;
    localparam int HUE_GREEN_OFS = 60;
    localparam int HUE_BLUE_OFS  = 120;
    localparam int HUE_TURN      = 180;
    localparam int HUE_LIMIT     = 180;
    localparam int SAT_SCALE     = 255;

    // Sector codes, chosen by which channel holds the maximum.
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // Input pixel.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pix_t;

    // Output pixel.
    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] brightness;
    } hsv_t;

    // Front stage: extremes, chroma and sector.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] maxv;
        logic [CH_W-1:0] chroma;
        logic [1:0]      sector;
    } front_t;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [CH_W-1:0]  dvs;
        logic [CH_W-1:0]  quo;
    } div_lane_t;

    // Payload of the divider stages: two lanes plus the side information.
    typedef struct packed {
        div_lane_t       sat;
        div_lane_t       hue;
        logic            sat_zero;
        logic            hue_zero;
        logic [CH_W-1:0] brightness;
    } div_pipe_t;

endpackage

`default_nettype wire

// File: hw/rtl/b2h_div_step.sv
// One quotient bit of the saturation and hue dividers.
`default_nettype none

module b2h_div_step
    import b2h_pkg::*;
(
    input  div_pipe_t         cur,
    input  logic [STEP_W-1:0] bit_idx,
    output div_pipe_t         nxt
);

    // Compare the partial remainder against the shifted divisor and subtract.
    function automatic div_lane_t lane_step(div_lane_t l, logic [STEP_W-1:0] sh);
        div_lane_t        r;
        logic [NUM_W-1:0] trial;
        r     = l;
        trial = NUM_W'(l.dvs) << sh;
        if (l.rem >= trial)
        begin
            r.rem     = l.rem - trial;
            r.quo[sh] = 1'b1;
        end
        return r;
    endfunction

    // Both lanes advance by one bit; the side information rides along.
    always_comb
    begin
        nxt     = cur;
        nxt.sat = lane_step(cur.sat, bit_idx);
        nxt.hue = lane_step(cur.hue, bit_idx);
    end

endmodule

`default_nettype wire

// File: hw/rtl/bgr_to_hsv_pixel.sv
// Top level of the pipelined BGR to HSV pixel converter.
//
// Usage: a pixel (blue, green, red) is offered on pix with pix_valid and is
// taken on a transfer where pix_valid and pix_ready are both high. The
// result (hue in half degrees, saturation, brightness) leaves on hsv with
// hsv_valid and is taken on a transfer where hsv_valid and hsv_ready are
// both high. Results come out in input order, one per pixel.
// Pipeline: ten stages in all: one front stage (max, min, sector), one
// numerator stage, and eight divider stages, each resolving one quotient bit
// of both the saturation and the hue division.
// Throughput: one pixel per clock while the receiver takes results.
// Stalls: each stage holds its item until the next stage is free, so empty
// stages keep filling while hsv_ready is low and pix_ready stays high until
// every stage holds an item. Nothing is dropped or repeated.
// Reset: rst_n clears all stage valid bits; the pipeline comes up empty.
`default_nettype none

module bgr_to_hsv_pixel
    import b2h_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pix_valid,
    output logic pix_ready,
    input  pix_t pix,
    output logic hsv_valid,
    input  logic hsv_ready,
    output hsv_t hsv
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    front_t    front_reg;
    front_t    front_next;
    div_pipe_t num_reg;
    div_pipe_t num_next;
    div_pipe_t div_reg  [DIV_STEPS];
    div_pipe_t div_next [DIV_STEPS];

    // A stage may load when it is empty or its item moves on in this cycle.
    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || hsv_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i + 1];
        end
    end

    assign pix_ready = adv[0];

    // Valid bits follow the items from stage to stage.
    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = pix_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Front stage: largest and smallest channel, chroma, sector.
    always_comb
    begin
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        mx = pix.red;
        mn = pix.red;
        if (pix.green > mx)
        begin
            mx = pix.green;
        end
        if (pix.blue > mx)
        begin
            mx = pix.blue;
        end
        if (pix.green < mn)
        begin
            mn = pix.green;
        end
        if (pix.blue < mn)
        begin
            mn = pix.blue;
        end
        front_next.blue   = pix.blue;
        front_next.green  = pix.green;
        front_next.red    = pix.red;
        front_next.maxv   = mx;
        front_next.chroma = mx - mn;
        if (mx == pix.red)
        begin
            front_next.sector = SECT_RED;
        end
        else if (mx == pix.green)
        begin
            front_next.sector = SECT_GREEN;
        end
        else
        begin
            front_next.sector = SECT_BLUE;
        end
    end

    // Numerator stage: 255 * chroma for saturation, sector formula for hue.
    always_comb
    begin
        logic signed [HNUM_W-1:0] d_s;
        logic signed [HNUM_W-1:0] hnum;
        d_s = HNUM_W'(signed'({1'b0, front_reg.chroma}));
        case (front_reg.sector)
            SECT_RED:
            begin
                hnum = HNUM_W'(HUE_SCALE) *
                       (HNUM_W'(signed'({1'b0, front_reg.green})) -
                        HNUM_W'(signed'({1'b0, front_reg.blue})));
                if (hnum < 0)
                begin
                    hnum = hnum + HNUM_W'(HUE_TURN) * d_s;
                end
            end
            SECT_GREEN:
            begin
                hnum = HNUM_W'(HUE_GREEN_OFS) * d_s + HNUM_W'(HUE_SCALE) *
                       (HNUM_W'(signed'({1'b0, front_reg.blue})) -
                        HNUM_W'(signed'({1'b0, front_reg.red})));
            end
            default:
            begin
                hnum = HNUM_W'(HUE_BLUE_OFS) * d_s + HNUM_W'(HUE_SCALE) *
                       (HNUM_W'(signed'({1'b0, front_reg.red})) -
                        HNUM_W'(signed'({1'b0, front_reg.green})));
            end
        endcase
        num_next.sat.rem    = NUM_W'(NUM_W'(SAT_SCALE) * NUM_W'(front_reg.chroma));
        num_next.sat.dvs    = front_reg.maxv;
        num_next.sat.quo    = '0;
        num_next.hue.rem    = hnum[NUM_W-1:0];
        num_next.hue.dvs    = front_reg.chroma;
        num_next.hue.quo    = '0;
        num_next.sat_zero   = (front_reg.maxv == '0);
        num_next.hue_zero   = (front_reg.chroma == '0);
        num_next.brightness = front_reg.maxv;
    end

    // Divider stages, most significant quotient bit first.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        b2h_div_step u_step (
            .cur     ((k == 0) ? num_reg : div_reg[(k == 0) ? 0 : k - 1]),
            .bit_idx (STEP_W'(DIV_STEPS - 1 - k)),
            .nxt     (div_next[k])
        );
    end

    // Payload registers load together with their valid bits.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            front_reg <= front_next;
        end
        if (adv[1])
        begin
            num_reg <= num_next;
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (adv[k + 2])
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // Output: a gray pixel has hue 0, a black pixel saturation 0.
    always_comb
    begin
        hsv.hue        = div_reg[DIV_STEPS-1].hue_zero ? '0 : div_reg[DIV_STEPS-1].hue.quo;
        hsv.saturation = div_reg[DIV_STEPS-1].sat_zero ? '0 : div_reg[DIV_STEPS-1].sat.quo;
        hsv.brightness = div_reg[DIV_STEPS-1].brightness;
    end

    assign hsv_valid = valid_reg[LAST];

    // The pipeline takes a pixel whenever the output stage is free.
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        !valid_reg[LAST] |-> pix_ready
    ) else $error("pix_ready low while the output stage is empty");

    // A held item in the front stage keeps its valid bit.
    a_hold_keeps_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !adv[0]) |=> valid_reg[0]
    ) else $error("front stage lost an item while stalled");

    // Hue stays below a full turn (180 half degrees).
    a_hue_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.hue < CH_W'(HUE_LIMIT))
    ) else $error("hue out of range");

    // A black pixel has neither hue nor saturation.
    a_black_pixel: assert property (
        @(posedge clk) disable iff (!rst_n)
        (hsv_valid && hsv.brightness == '0) |-> (hsv.hue == '0 && hsv.saturation == '0)
    ) else $error("black pixel with nonzero hue or saturation");

endmodule

`default_nettype wire

// File: tb/hsv_checker.sv
// Scoreboard for the BGR to HSV converter: predicts each pixel's result and compares it.
`timescale 1ns / 1ps

module hsv_checker
    import b2h_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pix_valid,
    input  logic pix_ready,
    input  pix_t pix,
    input  logic hsv_valid,
    input  logic hsv_ready,
    input  hsv_t hsv,
    output int   errors,
    output int   pending,
    output int   checked
);

    // Printing stops after this many reports so a broken block cannot flood the log.
    localparam int REPORT_CAP = 40;

    hsv_t expected_hsv[$];
    int   error_total   = 0;
    int   checked_total = 0;

    // Exact integer HSV of one pixel; hue is kept in half degrees over the chroma.
    function automatic hsv_t predict_hsv(pix_t p);
        int   b;
        int   g;
        int   r;
        int   hi;
        int   lo;
        int   chroma;
        int   hue_num;
        int   hue_half;
        int   sat;
        hsv_t res;
        b        = int'(p.blue);
        g        = int'(p.green);
        r        = int'(p.red);
        hi       = r;
        lo       = r;
        hue_half = 0;
        sat      = 0;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        chroma = hi - lo;
        if (hi != 0)
            sat = (255 * chroma) / hi;
        // A gray pixel has no hue; otherwise pick the sector by the leading channel.
        if (chroma != 0)
        begin
            if (hi == r)
                hue_num = 30 * (g - b);
            else if (hi == g)
                hue_num = 60 * chroma + 30 * (b - r);
            else
                hue_num = 120 * chroma + 30 * (r - g);
            if (hue_num < 0)
                hue_num += 180 * chroma;
            hue_half = hue_num / chroma;
            if (hue_half > 180)
                hue_half = 180;
            if (hue_half < 0)
                hue_half = 0;
        end
        if (sat > 255)
            sat = 255;
        res.hue        = hue_half[7:0];
        res.saturation = sat[7:0];
        res.brightness = hi[7:0];
        return res;
    endfunction

    // Compare one field of a result and report a difference.
    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            error_total++;
            if (error_total <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    // Record each input transfer and check each output transfer against the oldest entry.
    always @(posedge clk)
    begin
        hsv_t want;
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
                expected_hsv.push_back(predict_hsv(pix));
            if (hsv_valid && hsv_ready)
            begin
                if (expected_hsv.size() == 0)
                begin
                    error_total++;
                    if (error_total <= REPORT_CAP)
                        $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                                 $time, hsv.hue, hsv.saturation, hsv.brightness);
                end
                else
                begin
                    want = expected_hsv.pop_front();
                    compare_field("hue", want.hue, hsv.hue);
                    compare_field("saturation", want.saturation, hsv.saturation);
                    compare_field("brightness", want.brightness, hsv.brightness);
                    checked_total++;
                end
            end
            errors  <= error_total;
            pending <= expected_hsv.size();
            checked <= checked_total;
        end
    end

endmodule

// File: tb/tb.sv
// Top of the BGR to HSV converter testbench: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 1ps

module tb
    import b2h_pkg::*;
();

    localparam int RANDOM_MAIN  = 800;
    localparam int RANDOM_LATE  = 700;
    localparam int RANDOM_CLEAN = 300;
    localparam int BURST_ITEMS  = 60;
    localparam int LONG_HOLD    = 40;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic pix_valid;
    logic pix_ready;
    pix_t pix;
    logic hsv_valid;
    logic hsv_ready;
    hsv_t hsv;

    int errors;
    int pending;
    int checked;

    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;
    int hold_requests = 0;
    int sent_total    = 0;
    int stall_left    = 0;

    bgr_to_hsv_pixel u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv)
    );

    hsv_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Known input levels from time zero, then a single reset pulse.
    initial
    begin
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix       = '0;
        hsv_ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #5ms;
        $display("Timeout: %0d pixels sent, %0d results checked", sent_total, checked);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random short stalls, one long hold-off on request, none at the end.
    initial
    begin
        int holds_done;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                hsv_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_requests != holds_done)
            begin
                holds_done++;
                stall_left = LONG_HOLD - 1;
                hsv_ready <= 1'b0;
            end
            else if (receiver_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                hsv_ready <= 1'b0;
            end
            else
                hsv_ready <= 1'b1;
        end
    end

    // Offer one pixel, possibly after an idle burst, and hold it until its transfer.
    task automatic send_pixel(input pix_t p);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (!pix_ready);
        sent_total++;
    endtask

    function automatic pix_t make_pixel(input int b, input int g, input int r);
        pix_t p;
        p.blue  = b[7:0];
        p.green = g[7:0];
        p.red   = r[7:0];
        return p;
    endfunction

    // Random pixel mix: partly uniform, partly gray, ties, tiny and saturated channels.
    function automatic pix_t random_pixel();
        pix_t p;
        int   v;
        p = pix_t'(24'($urandom));
        v = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            0: p = make_pixel(v, v, v);
            1: p.green = p.red;
            2: p.blue = p.green;
            3: p.red = p.blue;
            4: p = make_pixel($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            5: p.red = 8'hff;
            default: ;
        endcase
        return p;
    endfunction

    task automatic wait_for_drain();
        while (pending != 0)
            @(posedge clk);
    endtask

    // Main stimulus sequence and verdict.
    initial
    begin
        int   k;
        pix_t directed[$];

        directed = '{
            make_pixel(0, 0, 0),       make_pixel(255, 255, 255), make_pixel(128, 128, 128),
            make_pixel(0, 0, 255),     make_pixel(0, 255, 0),     make_pixel(255, 0, 0),
            make_pixel(0, 255, 255),   make_pixel(255, 255, 0),   make_pixel(255, 0, 255),
            make_pixel(10, 200, 200),  make_pixel(200, 200, 10),  make_pixel(200, 10, 200),
            make_pixel(200, 10, 255),  make_pixel(1, 0, 255),     make_pixel(0, 0, 1),
            make_pixel(1, 1, 0),       make_pixel(85, 170, 85),   make_pixel(170, 85, 170),
            make_pixel(255, 254, 0),   make_pixel(0, 1, 255),     make_pixel(254, 255, 253),
            make_pixel(1, 2, 3)
        };

        @(posedge rst_n);
        @(posedge clk);

        // Directed corners with idling on both sides.
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        foreach (directed[i])
            send_pixel(directed[i]);

        for (k = 0; k < RANDOM_MAIN; k++)
            send_pixel(random_pixel());

        // Long result hold-off while pixels keep coming, so the pipeline backs up.
        sender_idle = 1'b0;
        hold_requests++;
        for (k = 0; k < BURST_ITEMS; k++)
            send_pixel(random_pixel());

        // Sender pause until every outstanding result has been seen.
        pix_valid <= 1'b0;
        @(posedge clk);
        wait_for_drain();
        sender_idle = 1'b1;

        for (k = 0; k < RANDOM_LATE; k++)
            send_pixel(random_pixel());

        // Final stretch at full rate on both sides.
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        for (k = 0; k < RANDOM_CLEAN; k++)
            send_pixel(random_pixel());
        pix_valid <= 1'b0;

        for (k = 0; k < 2000 && pending != 0; k++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $display("%0t ns: %0d results never arrived", $time, pending);
        $display("Sent %0d pixels (corners, gray, ties, hue wrap, random mix); checked %0d.",
                 sent_total, checked);
        $display("Traffic included random stalls, a %0d-cycle output hold-off and a drain pause.",
                 LONG_HOLD);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
